// ----- design/gcc_pkg.sv -----
// gcc_pkg: shared types and constants for the graph cycle checker
// no dependencies; imported by every module of the block
`default_nettype none

package gcc_pkg;

  localparam int NUM_NODES = 64;
  localparam int NODE_W    = 6;
  localparam int ACT_W     = 2;

  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [NUM_NODES-1:0] row_t;

  // action codes of an input word
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_PICK,
    ST_MERGE,
    ST_DONE
  } state_t;

  // commands from the sequencer to the search frontier
  typedef struct packed {
    logic init;   // start a search at start_node
    logic mark;   // flag the picked node as expanded
    logic merge;  // or an adjacency row into the reached set
  } frontier_cmd_t;

endpackage

`default_nettype wire

// ----- design/gcc_adj_mem.sv -----
// gcc_adj_mem: adjacency matrix, one row per source node, with per-row valid bits
// depends on gcc_pkg; rows never written or cleared read back as all zero
`default_nettype none

module gcc_adj_mem
  import gcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  clr,
  input  wire logic  rd_en,
  input  wire node_t rd_addr,
  output row_t       rd_row,
  input  wire logic  wr_en,
  input  wire node_t wr_addr,
  input  wire row_t  wr_row
);

  row_t mem [NUM_NODES];
  row_t row_valid;
  row_t rd_data;
  logic rd_valid;

  // row valid bits, cleared at once by reset or a clear word
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // storage write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= row_valid[rd_addr];
    end
  end

  // an unwritten row reads as no edges
  assign rd_row = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire

// ----- design/gcc_frontier.sv -----
// gcc_frontier: reached and expanded node sets of a reachability search
// depends on gcc_pkg; picks the lowest reached node not yet expanded
`default_nettype none

module gcc_frontier
  import gcc_pkg::*;
(
  input  wire logic          clk,
  input  wire frontier_cmd_t cmd,
  input  wire node_t         start_node,
  input  wire row_t          merge_row,
  input  wire node_t         goal_node,
  output logic               goal_hit,
  output logic               pending,
  output node_t              pick_node
);

  row_t reached;
  row_t expanded;
  row_t open_set;

  // set updates
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      reached  <= row_t'(1) << start_node;
      expanded <= '0;
    end else begin
      if (cmd.merge) begin
        reached <= reached | merge_row;
      end
      if (cmd.mark) begin
        expanded[pick_node] <= 1'b1;
      end
    end
  end

  assign open_set = reached & ~expanded;
  assign pending  = |open_set;
  assign goal_hit = reached[goal_node];

  // lowest open node
  always_comb begin
    pick_node = '0;
    for (int i = NUM_NODES - 1; i >= 0; i--) begin
      if (open_set[i]) begin
        pick_node = node_t'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/graph_cycle_check.sv -----
// graph_cycle_check: top level, sequencer and output register
// depends on gcc_pkg, gcc_adj_mem and gcc_frontier
`default_nettype none

// Holds a directed graph over 64 nodes as an adjacency bit matrix and answers
// whether a new link source -> target would close a cycle (target reaches
// source, or the two are equal). Every input word gives exactly one result
// word; cycle_found is 0 for add, clear and unused actions. One word is worked
// on at a time and in_stall is high until its result is handed to the output
// register. An enabled add goes through row read, row write and result; a
// clear, a disabled add, an unused action or a trivial query goes straight to
// the result. A query expands one reached node at a time, each as a pick with a
// read through the single read port of the adjacency memory and a merge. Since
// the search stops once source is reached, at most 63 nodes are expanded. A
// stalled output register holds the result back further.
// Clear and reset empty the graph at once.
module graph_cycle_check
  import gcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ACT_W-1:0]  action,
  input  wire logic [NODE_W-1:0] source_node,
  input  wire logic [NODE_W-1:0] target_node,
  input  wire logic              link_enabled,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   cycle_found
);

  state_t        state, state_next;
  node_t         src, src_next;
  node_t         dst, dst_next;
  logic          found, found_next;
  logic          out_valid_next;
  logic          out_load;

  logic          mem_clr;
  logic          mem_rd_en;
  node_t         mem_rd_addr;
  row_t          mem_rd_row;
  logic          mem_wr_en;
  row_t          mem_wr_row;

  frontier_cmd_t fcmd;
  logic          goal_hit;
  logic          pending;
  node_t         pick_node;

  gcc_adj_mem u_adj_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (mem_clr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_row  (mem_rd_row),
    .wr_en   (mem_wr_en),
    .wr_addr (src),
    .wr_row  (mem_wr_row)
  );

  gcc_frontier u_frontier (
    .clk        (clk),
    .cmd        (fcmd),
    .start_node (target_node),
    .merge_row  (mem_rd_row),
    .goal_node  (src),
    .goal_hit   (goal_hit),
    .pending    (pending),
    .pick_node  (pick_node)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src   <= src_next;
    dst   <= dst_next;
    found <= found_next;
    if (out_load) begin
      cycle_found <= found;
    end
  end

  assign mem_wr_row = mem_rd_row | (row_t'(1) << dst);

  // sequencer
  always_comb begin
    state_next  = state;
    src_next    = src;
    dst_next    = dst;
    found_next  = found;
    in_stall    = (state != ST_IDLE);
    out_load    = 1'b0;
    mem_clr     = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = source_node;
    mem_wr_en   = 1'b0;
    fcmd        = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          src_next   = source_node;
          dst_next   = target_node;
          found_next = 1'b0;
          state_next = ST_DONE;
          case (action_t'(action))
            ACT_ADD: begin
              if (link_enabled) begin
                mem_rd_en  = 1'b1;
                state_next = ST_ADD_WR;
              end
            end
            ACT_QUERY: begin
              if (source_node == target_node) begin
                found_next = 1'b1;
              end else begin
                fcmd.init  = 1'b1;
                state_next = ST_PICK;
              end
            end
            ACT_CLEAR: begin
              mem_clr = 1'b1;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_ADD_WR: begin
        mem_wr_en  = 1'b1;
        state_next = ST_DONE;
      end
      ST_PICK: begin
        if (goal_hit) begin
          found_next = 1'b1;
          state_next = ST_DONE;
        end else if (!pending) begin
          state_next = ST_DONE;
        end else begin
          fcmd.mark   = 1'b1;
          mem_rd_en   = 1'b1;
          mem_rd_addr = pick_node;
          state_next  = ST_MERGE;
        end
      end
      ST_MERGE: begin
        fcmd.merge = 1'b1;
        state_next = ST_PICK;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output word register
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    if (out_load) begin
      out_valid_next = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- bench/cycle_answer_checker.sv -----
// cycle_answer_checker: watches both channels of graph_cycle_check, predicts each answer
// from its own copy of the link graph and compares; depends on gcc_pkg
`default_nettype none

module cycle_answer_checker
  import gcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [ACT_W-1:0]  action,
  input  wire logic [NODE_W-1:0] source_node,
  input  wire logic [NODE_W-1:0] target_node,
  input  wire logic              link_enabled,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic              cycle_found,
  output int                     mismatch_count,
  output int                     answers_waiting
);

  timeunit 1ns;
  timeprecision 1ps;

  // predicted graph: bit t of row s means an enabled link s -> t
  row_t graph_rows [NUM_NODES];
  logic answers_due [$];
  int   failures;
  int   reported;

  // true when node goal can be reached from node start over recorded links
  function automatic logic reaches(input node_t start, input node_t goal);
    row_t reached;
    row_t grown;
    logic changed;
    reached        = '0;
    reached[start] = 1'b1;
    do begin
      grown = reached;
      for (int n = 0; n < NUM_NODES; n++)
        if (reached[n]) grown |= graph_rows[n];
      changed = (grown != reached);
      reached = grown;
    end while (changed);
    return reached[goal];
  endfunction

  // apply one word to the predicted graph and return the answer it must give
  function automatic logic cycle_would_close(input logic [ACT_W-1:0] act, input node_t src,
                                             input node_t dst, input logic en);
    logic found;
    found = 1'b0;
    case (act)
      ACT_ADD: begin
        if (en) graph_rows[src][dst] = 1'b1;
      end
      ACT_QUERY: begin
        if (src == dst) found = 1'b1;
        else found = reaches(dst, src);
      end
      ACT_CLEAR: begin
        foreach (graph_rows[i]) graph_rows[i] = '0;
      end
      default: ;
    endcase
    return found;
  endfunction

  always @(posedge clk) begin
    logic want;
    if (rst) begin
      foreach (graph_rows[i]) graph_rows[i] = '0;
      answers_due.delete();
    end else begin
      // result side: compare with the oldest expected answer
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          failures++;
          if (reported < 10) begin
            reported++;
            $display("%0t: result word with no word outstanding, cycle_found=%0b",
                     $realtime, cycle_found);
          end
        end else begin
          want = answers_due.pop_front();
          if (cycle_found !== want) begin
            failures++;
            if (reported < 10) begin
              reported++;
              $display("%0t: cycle_found mismatch, expected %0b got %0b",
                       $realtime, want, cycle_found);
            end
          end
        end
      end
      // input side: predict the answer of each accepted word
      if (in_valid && !in_stall)
        answers_due = {answers_due, cycle_would_close(action, source_node, target_node,
                                                      link_enabled)};
    end
    mismatch_count  <= failures;
    answers_waiting <= answers_due.size();
  end

endmodule

`default_nettype wire

// ----- bench/graph_cycle_check_test.sv -----
// graph_cycle_check_test: stimulus, flow control and verdict for graph_cycle_check
// depends on gcc_pkg, the graph_cycle_check RTL and cycle_answer_checker
`default_nettype none

module graph_cycle_check_test;
  import gcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;
  localparam int               WORD_TARGET = 1250;
  localparam int               DRAIN_WAIT  = 140;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [ACT_W-1:0]  action       = ACT_ADD;
  logic [NODE_W-1:0] source_node  = '0;
  logic [NODE_W-1:0] target_node  = '0;
  logic              link_enabled = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic              cycle_found;

  int    mismatch_count;
  int    answers_waiting;
  int    words_sent    = 0;
  bit    steady_sender = 1'b0;
  node_t pool [NUM_NODES];
  int    pool_size;

  graph_cycle_check DUT (
    .clk, .rst, .in_valid, .in_stall, .action, .source_node, .target_node,
    .link_enabled, .out_valid, .out_stall, .cycle_found
  );

  cycle_answer_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .action, .source_node, .target_node,
    .link_enabled, .out_valid, .out_stall, .cycle_found, .mismatch_count,
    .answers_waiting
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // offer one word, hold it until accepted, then maybe leave a gap
  task automatic send_word(input logic [ACT_W-1:0] act, input node_t src, input node_t dst,
                           input logic en);
    int roll;
    int gap;
    in_valid     <= 1'b1;
    action       <= act;
    source_node  <= src;
    target_node  <= dst;
    link_enabled <= en;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    roll = $urandom_range(0, 99);
    if (steady_sender || roll < 50) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic node_t pool_node();
    return pool[$urandom_range(0, pool_size - 1)];
  endfunction

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    bit holdoff_done;
    int roll;
    int span;
    holdoff_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!holdoff_done && words_sent >= 300) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        holdoff_done = 1'b1;
      end
      out_stall <= 1'b0;
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 8);
      repeat (span) @(posedge clk);
      roll = $urandom_range(0, 99);
      if (roll < 60) span = 0;
      else if (roll < 95) span = $urandom_range(1, 3);
      else span = $urandom_range(15, 60);
      if (span > 0) begin
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin
    int roll;
    int ops;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed words: node extremes, repeats, disabled links, every action
    send_word(ACT_QUERY,  6'd0,  6'd0,  1'b0);  // same node is always a cycle
    send_word(ACT_QUERY,  6'd63, 6'd63, 1'b1);
    send_word(ACT_ADD,    6'd0,  6'd63, 1'b1);
    send_word(ACT_ADD,    6'd0,  6'd63, 1'b1);  // repeated link
    send_word(ACT_ADD,    6'd63, 6'd0,  1'b0);  // disabled link sets nothing
    send_word(ACT_QUERY,  6'd0,  6'd63, 1'b0);
    send_word(ACT_QUERY,  6'd63, 6'd0,  1'b0);
    send_word(ACT_ADD,    6'd63, 6'd21, 1'b1);
    send_word(ACT_ADD,    6'd21, 6'd42, 1'b1);
    send_word(ACT_QUERY,  6'd42, 6'd0,  1'b0);  // reached over three links
    send_word(ACT_QUERY,  6'd0,  6'd42, 1'b0);
    send_word(ACT_UNUSED, 6'd63, 6'd63, 1'b1);
    send_word(ACT_QUERY,  6'd21, 6'd0,  1'b1);
    send_word(ACT_CLEAR,  6'd63, 6'd0,  1'b1);
    send_word(ACT_QUERY,  6'd63, 6'd0,  1'b0);  // graph gone after clear
    send_word(ACT_ADD,    6'd42, 6'd42, 1'b1);  // self loop
    send_word(ACT_QUERY,  6'd42, 6'd42, 1'b0);
    send_word(ACT_QUERY,  6'd42, 6'd21, 1'b0);
    send_word(ACT_UNUSED, 6'd0,  6'd0,  1'b0);
    send_word(ACT_QUERY,  6'd42, 6'd21, 1'b1);

    // random episodes: fresh graph over a node pool, links and queries mixed
    while (words_sent < WORD_TARGET) begin
      steady_sender = ($urandom_range(0, 5) == 0);
      roll = $urandom_range(0, 9);
      if (roll < 7) pool_size = $urandom_range(2, 8);
      else if (roll < 9) pool_size = $urandom_range(9, 20);
      else pool_size = NUM_NODES;
      for (int i = 0; i < pool_size; i++) pool[i] = node_t'($urandom_range(0, 63));
      send_word(ACT_CLEAR, node_t'($urandom), node_t'($urandom), 1'($urandom));
      // sometimes start from a chain through the whole pool for long searches
      if ($urandom_range(0, 4) == 0)
        for (int i = 0; i + 1 < pool_size; i++)
          send_word(ACT_ADD, pool[i], pool[i + 1], 1'b1);
      ops = $urandom_range(10, 40);
      repeat (ops) begin
        roll = $urandom_range(0, 99);
        if (roll < 45)
          send_word(ACT_ADD, pool_node(), pool_node(), 1'($urandom_range(0, 9) != 0));
        else if (roll < 85)
          send_word(ACT_QUERY, pool_node(), pool_node(), 1'($urandom));
        else if (roll < 92)
          send_word(($urandom_range(0, 1) == 0) ? ACT_ADD : ACT_QUERY,
                    node_t'($urandom), node_t'($urandom), 1'($urandom));
        else if (roll < 97)
          send_word(ACT_UNUSED, node_t'($urandom), node_t'($urandom), 1'($urandom));
        else
          send_word(ACT_CLEAR, node_t'($urandom), node_t'($urandom), 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    // drain outstanding answers, then give the block time to settle
    @(posedge clk);
    while (answers_waiting != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/gcc_pkg.sv
design/gcc_adj_mem.sv
design/gcc_frontier.sv
design/graph_cycle_check.sv
bench/cycle_answer_checker.sv
bench/graph_cycle_check_test.sv
